>>> rtl/core/two_axis_step_sequencer_core_macros.svh
// Assertion macros for the step sequencer.
`ifndef TWO_AXIS_STEP_SEQUENCER_CORE_MACROS_SVH
`define TWO_AXIS_STEP_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication.
`define TASS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TASS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tass_pkg.sv
`default_nettype none

package tass_pkg;

   localparam int COUNT_BITS_DEF    = 24;
   localparam int BACKOFF_STEPS_DEF = 20;
   localparam int MOVE_W            = 24;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_MOVE = 2'd1;
   localparam logic [1:0] KIND_HOME = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_SEEK = 2'd2,
      MODE_BACK = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PLAN_X_ONLY  = 2'd0,
      PLAN_Y_ONLY  = 2'd1,
      PLAN_Y_MAJOR = 2'd2,
      PLAN_X_MAJOR = 2'd3
   } plan_type;

   typedef enum logic {
      SEQ_READY  = 1'b0,
      SEQ_DIVIDE = 1'b1
   } seq_type;

   typedef enum logic {
      DIV_IDLE = 1'b0,
      DIV_RUN  = 1'b1
   } div_state_type;

endpackage

`default_nettype wire

>>> rtl/core/tass_divider.sv
`default_nettype none

module tass_divider
   import tass_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COUNT_BITS-1:0] dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output logic                       done,
   output logic [COUNT_BITS-1:0]      quotient
);

   localparam int CW = $clog2(COUNT_BITS);

   div_state_type          state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  quo_ff, quo_in;
   logic [COUNT_BITS-1:0]  dsr_ff, dsr_in;
   logic                   done_ff, done_in;
   logic [COUNT_BITS:0]    rem_shift;
   logic [COUNT_BITS:0]    diff;
   logic                   ge;
   logic                   last_step;

   assign rem_shift = {rem_ff, quo_ff[COUNT_BITS-1]};
   assign diff      = rem_shift - {1'b0, dsr_ff};
   assign ge        = !diff[COUNT_BITS];
   assign last_step = (cnt_ff == CW'(COUNT_BITS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) state_in = DIV_RUN;
         end
         DIV_RUN: begin
            if (last_step) state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               cnt_in = '0;
               rem_in = '0;
               quo_in = dividend;
               dsr_in = divisor;
            end
         end
         DIV_RUN: begin
            rem_in  = ge ? diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
            quo_in  = {quo_ff[COUNT_BITS-2:0], ge};
            cnt_in  = cnt_ff + 1'b1;
            done_in = last_step;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/two_axis_step_sequencer_core.sv
// Channel | Dir | Payload                                         | Sideband
// req     | in  | tdata: move_dx, move_dy, x_min, x_max, y_min,   | tuser: kind
//         |     |        y_max                                    |
// rsp     | out | tdata: step_x, step_y, dir_x, dir_y, busy_res   | tlast: done_res
//
// Ticks and home commands never start the divider. A move with two nonzero counts runs
// one restoring division, one quotient bit per cycle, before the next item is taken.
// Reset is synchronous; all sequencing state clears to idle.
// One result item per input item, held in an output register; the input stalls
// only while that register is full and not taken, or while the divider runs.
`default_nettype none

module two_axis_step_sequencer_core
   import tass_pkg::*;
#(
   parameter int COUNT_BITS    = COUNT_BITS_DEF,
   parameter int BACKOFF_STEPS = BACKOFF_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [23:0] move_dx, [47:24] move_dy, [48] x_min_hit, [49] x_max_hit,
   // [50] y_min_hit, [51] y_max_hit, [55:52] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] step_x, [1] step_y, [2] dir_x, [3] dir_y, [4] busy_res, [7:5] zero
   output logic [7:0]       rsp_tdata,
   // done_res
   output logic             rsp_tlast
);

   `include "two_axis_step_sequencer_core_macros.svh"

   localparam int WIDE = (COUNT_BITS > MOVE_W) ? COUNT_BITS : MOVE_W;
   localparam logic [WIDE-1:0] CNT_MASK_W = WIDE'({COUNT_BITS{1'b1}});
   localparam int BW = $clog2(BACKOFF_STEPS + 1);

   seq_type                seq_ff, seq_in;
   mode_type               mode_ff, mode_in;
   plan_type               plan_ff, plan_in;
   logic [COUNT_BITS-1:0]  ticks_ff, ticks_in;
   logic [COUNT_BITS-1:0]  phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  ratio_ff;
   logic                   halt_x_ff, halt_x_in;
   logic                   halt_y_ff, halt_y_in;
   logic [3:0]             prev_ff;
   logic [1:0]             dir_ff, dir_in;
   logic [BW-1:0]          backoff_ff, backoff_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   step_x_ff, step_x_in;
   logic                   step_y_ff, step_y_in;
   logic                   busy_ff;
   logic                   done_ff, done_in;

   logic                   req_accept;
   logic [MOVE_W-1:0]      dx, dy;
   logic [3:0]             lim;
   logic [3:0]             rise;
   logic                   nx, zx, ny, zy;
   logic [MOVE_W-1:0]      ax, ay;
   logic [WIDE-1:0]        wx, wy;
   logic [COUNT_BITS-1:0]  mx, my;
   logic                   hx, hy;
   logic                   both_tick;
   logic [COUNT_BITS-1:0]  phase_next;
   logic [COUNT_BITS-1:0]  ticks_dec;
   logic [BW-1:0]          backoff_dec;
   logic                   div_start;
   logic                   div_done;
   logic [COUNT_BITS-1:0]  div_quotient;
   logic [COUNT_BITS-1:0]  div_dividend, div_divisor;

   assign dx  = req_tdata[23:0];
   assign dy  = req_tdata[47:24];
   assign lim = req_tdata[51:48];

   assign req_tready = (seq_ff == SEQ_READY) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign nx = dx[MOVE_W-1];
   assign ny = dy[MOVE_W-1];
   assign zx = (dx == '0);
   assign zy = (dy == '0);
   assign ax = nx ? (MOVE_W'(0) - dx) : dx;
   assign ay = ny ? (MOVE_W'(0) - dy) : dy;
   assign wx = (WIDE'(ax) > CNT_MASK_W) ? CNT_MASK_W : WIDE'(ax);
   assign wy = (WIDE'(ay) > CNT_MASK_W) ? CNT_MASK_W : WIDE'(ay);
   assign mx = wx[COUNT_BITS-1:0];
   assign my = wy[COUNT_BITS-1:0];

   assign rise        = lim & ~prev_ff;
   assign both_tick   = (phase_ff == '0);
   assign phase_next  = (COUNT_BITS'(phase_ff + 1'b1) == ratio_ff) ? '0
                                                                   : COUNT_BITS'(phase_ff + 1'b1);
   assign ticks_dec   = (ticks_ff != '0) ? COUNT_BITS'(ticks_ff - 1'b1) : '0;
   assign backoff_dec = (backoff_ff != '0) ? BW'(backoff_ff - 1'b1) : '0;

   assign div_start    = req_accept && (req_tuser == KIND_MOVE) && !zx && !zy;
   assign div_dividend = (my >= mx) ? my : mx;
   assign div_divisor  = (my >= mx) ? mx : my;

   tass_divider #(
      .COUNT_BITS(COUNT_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_READY: begin
            if (div_start) seq_in = SEQ_DIVIDE;
         end
         SEQ_DIVIDE: begin
            if (div_done) seq_in = SEQ_READY;
         end
         default: seq_in = SEQ_READY;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      plan_in    = plan_ff;
      ticks_in   = ticks_ff;
      phase_in   = phase_ff;
      halt_x_in  = halt_x_ff;
      halt_y_in  = halt_y_ff;
      dir_in     = dir_ff;
      backoff_in = backoff_ff;
      step_x_in  = 1'b0;
      step_y_in  = 1'b0;
      done_in    = 1'b0;
      hx         = halt_x_ff;
      hy         = halt_y_ff;
      unique case (req_tuser)
         KIND_MOVE: begin
            dir_in    = {!ny && !zy, !nx && !zx};
            halt_x_in = (lim[0] && (nx || zx)) || (lim[1] && !nx);
            halt_y_in = (lim[2] && (ny || zy)) || (lim[3] && !ny);
            phase_in  = '0;
            if (zy) begin
               plan_in  = PLAN_X_ONLY;
               ticks_in = mx;
            end else if (zx) begin
               plan_in  = PLAN_Y_ONLY;
               ticks_in = my;
            end else if (my >= mx) begin
               plan_in  = PLAN_Y_MAJOR;
               ticks_in = my;
            end else begin
               plan_in  = PLAN_X_MAJOR;
               ticks_in = mx;
            end
            if (ticks_in == '0) begin
               mode_in = MODE_IDLE;
               done_in = 1'b1;
            end else begin
               mode_in = MODE_MOVE;
            end
         end
         KIND_HOME: begin
            mode_in    = MODE_SEEK;
            halt_x_in  = 1'b0;
            halt_y_in  = 1'b0;
            dir_in     = 2'b00;
            backoff_in = '0;
         end
         default: begin
            unique case (mode_ff)
               MODE_MOVE: begin
                  hx = halt_x_ff || rise[0] || rise[1];
                  hy = halt_y_ff || rise[2] || rise[3];
                  unique case (plan_ff)
                     PLAN_X_ONLY: step_x_in = !hx;
                     PLAN_Y_ONLY: step_y_in = !hy;
                     PLAN_Y_MAJOR: begin
                        step_x_in = both_tick && !hx && !hy;
                        step_y_in = both_tick ? (!hx && !hy) : !hy;
                     end
                     default: begin
                        step_x_in = both_tick ? (!hx && !hy) : !hx;
                        step_y_in = both_tick && !hx && !hy;
                     end
                  endcase
                  halt_x_in = hx;
                  halt_y_in = hy;
                  phase_in  = phase_next;
                  ticks_in  = ticks_dec;
                  if ((ticks_dec == '0) || (hx && hy)) begin
                     mode_in = MODE_IDLE;
                     done_in = 1'b1;
                  end
               end
               MODE_SEEK: begin
                  hx        = halt_x_ff || lim[0];
                  hy        = halt_y_ff || lim[2];
                  halt_x_in = hx;
                  halt_y_in = hy;
                  if (hx && hy) begin
                     dir_in     = 2'b11;
                     backoff_in = BW'(BACKOFF_STEPS);
                     mode_in    = MODE_BACK;
                  end else begin
                     step_x_in = !hx;
                     step_y_in = !hy;
                  end
               end
               MODE_BACK: begin
                  step_x_in  = 1'b1;
                  step_y_in  = 1'b1;
                  backoff_in = backoff_dec;
                  if (backoff_dec == '0) begin
                     mode_in = MODE_IDLE;
                     done_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_READY;
         mode_ff      <= MODE_IDLE;
         plan_ff      <= PLAN_X_ONLY;
         ticks_ff     <= '0;
         phase_ff     <= '0;
         halt_x_ff    <= 1'b0;
         halt_y_ff    <= 1'b0;
         prev_ff      <= '0;
         dir_ff       <= '0;
         backoff_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff    <= mode_in;
            plan_ff    <= plan_in;
            ticks_ff   <= ticks_in;
            phase_ff   <= phase_in;
            halt_x_ff  <= halt_x_in;
            halt_y_ff  <= halt_y_in;
            prev_ff    <= lim;
            dir_ff     <= dir_in;
            backoff_ff <= backoff_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) ratio_ff <= div_quotient;
      if (req_accept) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         busy_ff   <= (mode_in != MODE_IDLE);
         done_ff   <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, busy_ff, dir_ff[1], dir_ff[0], step_y_ff, step_x_ff};
   assign rsp_tlast  = done_ff;

   `TASS_ASSERT_NOW(a_div_done_in_divide, div_done, seq_ff == SEQ_DIVIDE,
                    "divider finished outside a divide phase")
   `TASS_ASSERT_NOW(a_ratio_nonzero,
                    (seq_ff == SEQ_READY) && (mode_ff == MODE_MOVE) &&
                    ((plan_ff == PLAN_X_MAJOR) || (plan_ff == PLAN_Y_MAJOR)),
                    ratio_ff != '0, "major-axis move running with zero ratio")
   `TASS_ASSERT_NOW(a_phase_below_ratio,
                    (seq_ff == SEQ_READY) && (mode_ff == MODE_MOVE) &&
                    ((plan_ff == PLAN_X_MAJOR) || (plan_ff == PLAN_Y_MAJOR)),
                    phase_ff < ratio_ff, "tick phase escaped its ratio")

endmodule

`default_nettype wire

>>> tb/sv/step_pulse_compare.sv
module step_pulse_compare
   import tass_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               mismatch_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic step_x;
      logic step_y;
      logic dir_x;
      logic dir_y;
      logic busy;
      logic done;
   } step_result_t;

   step_result_t expected_steps[$];
   int           fail_total = 0;

   mode_type     seq_mode;
   plan_type     plan;
   logic [23:0]  ticks_remaining;
   logic [23:0]  tick_count;
   logic [23:0]  ratio;
   logic         x_halted;
   logic         y_halted;
   logic [3:0]   last_limits;
   logic [1:0]   dirs;
   logic [4:0]   backoff_count;

   assign mismatch_count = fail_total;

   function automatic step_result_t advance_sequencer(input logic [1:0]  kind,
                                                      input logic [23:0] dx,
                                                      input logic [23:0] dy,
                                                      input logic [3:0]  lim);
      step_result_t r;
      logic [23:0]  mag_x, mag_y;
      logic         neg_x, neg_y, zero_x, zero_y, both_tick;
      logic [3:0]   rise;
      r = '0;
      if (kind == KIND_MOVE) begin
         neg_x  = dx[23];
         neg_y  = dy[23];
         zero_x = (dx == '0);
         zero_y = (dy == '0);
         mag_x  = neg_x ? -dx : dx;
         mag_y  = neg_y ? -dy : dy;
         dirs     = {!neg_y && !zero_y, !neg_x && !zero_x};
         x_halted = (lim[0] && (neg_x || zero_x)) || (lim[1] && !neg_x);
         y_halted = (lim[2] && (neg_y || zero_y)) || (lim[3] && !neg_y);
         tick_count = '0;
         ratio      = '0;
         if (zero_y) begin
            plan            = PLAN_X_ONLY;
            ticks_remaining = mag_x;
         end else if (zero_x) begin
            plan            = PLAN_Y_ONLY;
            ticks_remaining = mag_y;
         end else if (mag_y >= mag_x) begin
            plan            = PLAN_Y_MAJOR;
            ratio           = mag_y / mag_x;
            ticks_remaining = mag_y;
         end else begin
            plan            = PLAN_X_MAJOR;
            ratio           = mag_x / mag_y;
            ticks_remaining = mag_x;
         end
         if (ticks_remaining == '0) begin
            seq_mode = MODE_IDLE;
            r.done   = 1'b1;
         end else begin
            seq_mode = MODE_MOVE;
         end
      end else if (kind == KIND_HOME) begin
         seq_mode      = MODE_SEEK;
         x_halted      = 1'b0;
         y_halted      = 1'b0;
         dirs          = 2'b00;
         backoff_count = '0;
      end else if (seq_mode == MODE_MOVE) begin
         rise      = lim & ~last_limits;
         both_tick = (tick_count % ((ratio == '0) ? 24'd1 : ratio)) == '0;
         if (rise[1:0] != 2'b00) x_halted = 1'b1;
         if (rise[3:2] != 2'b00) y_halted = 1'b1;
         case (plan)
            PLAN_X_ONLY: r.step_x = !x_halted;
            PLAN_Y_ONLY: r.step_y = !y_halted;
            PLAN_Y_MAJOR: begin
               if (both_tick) begin
                  r.step_x = !x_halted && !y_halted;
                  r.step_y = r.step_x;
               end else begin
                  r.step_y = !y_halted;
               end
            end
            default: begin
               if (both_tick) begin
                  r.step_x = !x_halted && !y_halted;
                  r.step_y = r.step_x;
               end else begin
                  r.step_x = !x_halted;
               end
            end
         endcase
         tick_count = tick_count + 24'd1;
         if (ticks_remaining != '0) ticks_remaining = ticks_remaining - 24'd1;
         if (ticks_remaining == '0 || (x_halted && y_halted)) begin
            seq_mode = MODE_IDLE;
            r.done   = 1'b1;
         end
      end else if (seq_mode == MODE_SEEK) begin
         if (lim[0]) x_halted = 1'b1;
         if (lim[2]) y_halted = 1'b1;
         if (x_halted && y_halted) begin
            dirs          = 2'b11;
            backoff_count = 5'(BACKOFF_STEPS_DEF);
            seq_mode      = MODE_BACK;
            if (backoff_count == '0) begin
               seq_mode = MODE_IDLE;
               r.done   = 1'b1;
            end
         end else begin
            r.step_x = !x_halted;
            r.step_y = !y_halted;
         end
      end else if (seq_mode == MODE_BACK) begin
         r.step_x = 1'b1;
         r.step_y = 1'b1;
         if (backoff_count != '0) backoff_count = backoff_count - 5'd1;
         if (backoff_count == '0) begin
            seq_mode = MODE_IDLE;
            r.done   = 1'b1;
         end
      end
      last_limits = lim;
      r.dir_x = dirs[0];
      r.dir_y = dirs[1];
      r.busy  = (seq_mode != MODE_IDLE);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      step_result_t want, got;
      if (reset) begin
         seq_mode        = MODE_IDLE;
         plan            = PLAN_X_ONLY;
         ticks_remaining = '0;
         tick_count      = '0;
         ratio           = '0;
         x_halted        = 1'b0;
         y_halted        = 1'b0;
         last_limits     = '0;
         dirs            = '0;
         backoff_count   = '0;
         expected_steps.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_steps.push_back(advance_sequencer(req_tuser, req_tdata[23:0],
                                                       req_tdata[47:24], req_tdata[51:48]));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tdata[3], rsp_tdata[4],
                   rsp_tlast};
            if (expected_steps.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: unexpected result item sx=%0b sy=%0b dx=%0b dy=%0b busy=%0b done=%0b",
                           $time, got.step_x, got.step_y, got.dir_x, got.dir_y, got.busy,
                           got.done);
               fail_total++;
            end else begin
               want = expected_steps.pop_front();
               if (got.step_x !== want.step_x || got.step_y !== want.step_y ||
                   got.dir_x !== want.dir_x || got.dir_y !== want.dir_y ||
                   got.busy !== want.busy || got.done !== want.done) begin
                  if (fail_total < 10)
                     $display("%0t: expected sx=%0b sy=%0b dx=%0b dy=%0b busy=%0b done=%0b, %s",
                              $time, want.step_x, want.step_y, want.dir_x, want.dir_y,
                              want.busy, want.done,
                              $sformatf("got sx=%0b sy=%0b dx=%0b dy=%0b busy=%0b done=%0b",
                                        got.step_x, got.step_y, got.dir_x, got.dir_y,
                                        got.busy, got.done));
                  fail_total++;
               end
            end
         end
      end
      pending_count <= expected_steps.size();
   end

endmodule

>>> tb/sv/two_axis_step_sequencer_core_test.sv
module two_axis_step_sequencer_core_test
   import tass_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         DIRECTED_ITEMS = 25;
   localparam int         RANDOM_ITEMS   = 1025;
   localparam int         CYCLE_LIMIT    = 500000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam logic [1:0] KIND_SPARE     = 2'd3;

   typedef enum logic [1:0] {
      READY_ALWAYS  = 2'd0,
      READY_COIN    = 2'd1,
      READY_SPARSE  = 2'd2,
      READY_CADENCE = 2'd3
   } ready_style_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;

   int              burst_left  = 0;
   int              items_sent  = 0;
   int              cycle_count = 0;
   int              style_left  = 0;
   ready_style_type ready_style = READY_ALWAYS;

   two_axis_step_sequencer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   step_pulse_compare pulse_compare (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (fail_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style <= ready_style_type'($urandom_range(0, 3));
         style_left  <= $urandom_range(5, 60);
      end else begin
         style_left <= style_left - 1;
      end
      case (ready_style)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (cycle_count % 3 != 0);
      endcase
   end

   function automatic logic [23:0] rand_count();
      logic [23:0] v;
      case ($urandom_range(0, 9))
         0:       v = '0;
         7:       v = 24'($urandom_range(13, 60));
         8:       v = 24'($urandom);
         9:       v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: v = 24'($urandom_range(1, 12));
      endcase
      if (v != 24'h800000 && $urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   function automatic int unsigned major_span(input logic [23:0] dx, input logic [23:0] dy);
      logic [23:0] ax, ay;
      ax = dx[23] ? -dx : dx;
      ay = dy[23] ? -dy : dy;
      return 32'((ax > ay) ? ax : ay);
   endfunction

   task automatic send_item(input logic [1:0]  kind,
                            input logic [23:0] dx,
                            input logic [23:0] dy,
                            input logic [3:0]  lim);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, lim, dy, dx};
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // unused kind code behaves as a tick; mix it in now and then
   task automatic send_tick(input logic [3:0] lim);
      send_item(($urandom_range(0, 15) == 0) ? KIND_SPARE : KIND_TICK,
                24'($urandom), 24'($urandom), lim);
   endtask

   initial begin
      logic [23:0] dx, dy;
      logic [3:0]  lim;
      int unsigned n;
      int          pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_tick(4'hF);
      send_item(KIND_MOVE, 24'd0, 24'd0, 4'h0);
      send_item(KIND_MOVE, 24'h800000, 24'h7FFFFF, 4'h0);
      send_tick(4'h0);
      send_item(KIND_MOVE, 24'h7FFFFF, 24'h800000, 4'h0);
      send_item(KIND_SPARE, 24'hFFFFFF, 24'hFFFFFF, 4'h0);
      send_item(KIND_MOVE, 24'd2, 24'd5, 4'h0);
      repeat (5) send_tick(4'h0);
      // x major, y_max edge stops y, then x_min edge stops x on the last tick of the move
      send_item(KIND_MOVE, -24'd4, 24'd1, 4'h0);
      send_tick(4'h0);
      send_tick(4'h8);
      send_tick(4'h8);
      send_tick(4'h9);
      // both axes already resting on their min switches
      send_item(KIND_MOVE, -24'd3, -24'd2, 4'h5);
      send_tick(4'h5);
      send_item(KIND_MOVE, 24'd0, 24'd3, 4'h8);
      repeat (3) send_tick(4'h8);
      send_item(KIND_HOME, 24'd0, 24'd0, 4'h0);
      send_tick(4'h0);

      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            dx  = rand_count();
            dy  = rand_count();
            lim = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h0;
            send_item(KIND_MOVE, dx, dy, lim);
            n = major_span(dx, dy);
            n = (n > 64) ? $urandom_range(1, 40) : n + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
            repeat (n) begin
               if ($urandom_range(0, 24) == 0) lim ^= 4'b0001 << $urandom_range(0, 3);
               send_tick(lim);
            end
         end else if (pick < 15) begin
            lim = 4'($urandom);
            send_item(KIND_HOME, 24'($urandom), 24'($urandom), lim);
            if ($urandom_range(0, 4) != 0) lim = lim & 4'b1010;
            repeat ($urandom_range(0, 6)) begin
               lim[1] = 1'($urandom);
               lim[3] = 1'($urandom);
               send_tick(lim);
            end
            if ($urandom_range(0, 1) == 1) lim[0] = 1'b1;
            else lim[2] = 1'b1;
            repeat ($urandom_range(1, 3)) send_tick(lim);
            send_tick(lim | 4'b0101);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 20 + $urandom_range(0, 3);
            repeat (n) send_tick(4'($urandom));
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 8))
               send_item(2'($urandom), 24'($urandom), 24'($urandom), 4'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 1)
               send_item(KIND_MOVE, rand_count(), rand_count(), 4'($urandom));
            else
               send_item(KIND_HOME, 24'($urandom), 24'($urandom), 4'($urandom));
            repeat ($urandom_range(1, 15)) send_tick(4'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tass_pkg.sv
rtl/core/tass_divider.sv
rtl/core/two_axis_step_sequencer_core.sv
tb/sv/step_pulse_compare.sv
tb/sv/two_axis_step_sequencer_core_test.sv
